/* hw/rtl/pdmem_pkg.sv */
// ----------------------------------------------------------------------------
// pdmem_pkg
// Shared constants, types and the bit-count function of the PDM density and
// energy meter.
// ----------------------------------------------------------------------------
`default_nettype none

package pdmem_pkg;

  localparam int unsigned FrameWords = 64;
  localparam int unsigned PosW       = $clog2(FrameWords);
  localparam int unsigned WordW      = 16;
  localparam int unsigned CntW       = $clog2(WordW + 1);
  localparam int unsigned OnesW      = 7;
  localparam int unsigned DevW       = 6;
  localparam int unsigned SqW        = 2 * DevW;
  localparam int unsigned SumW       = 15;
  localparam int unsigned LevelW     = 11;
  localparam int unsigned EnergyShift = 4;
  localparam int unsigned OutDataW   = 16;

  localparam logic [OnesW-1:0] GroupCenter = OnesW'(32);
  localparam logic [SumW-1:0]  EnergyMax   = {SumW{1'b1}};
  localparam logic [PosW-1:0]  LastPos     = PosW'(FrameWords - 1);

  typedef enum logic {
    MODE_ENERGY  = 1'b0,
    MODE_DENSITY = 1'b1
  } mode_e;

  // staged beat between the bit-count stage and the accumulator
  typedef struct packed {
    logic            vld;
    logic [CntW-1:0] ones;
  } stage_t;

  function automatic logic [CntW-1:0] popcount(input logic [WordW-1:0] w);
    logic [CntW-1:0] n;
    n = '0;
    for (int b = 0; b < WordW; b++) begin
      n = n + CntW'(w[b]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pdm_density_energy_meter.sv */
// ----------------------------------------------------------------------------
// pdm_density_energy_meter
// Ones density and frame energy of a PDM microphone stream.
// ----------------------------------------------------------------------------
// Takes one 16-bit PDM word per cycle; the word that closes a result passes
// through the bit-count register, then the result register. In energy mode
// one result per 64-word frame: the saturated sum of squared deviations of
// each four-word ones count from 32, shifted right by 4. In density mode one
// result per word pair: the pair's ones count. tlast marks the result made by
// the last word of a frame. The rate is one word per cycle; it drops only when
// a result waits in the output register and the next word would make another.
// The user writes density_mode via cfg_we_i only while idle; not enforced.
`default_nettype none

module pdm_density_energy_meter (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_wdata_i,      // density_mode
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [15:0] s_axis_tdata_i,   // [15:0] pdm_word
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [10:0] level_value, [15:11] zero
  output logic        m_axis_tlast_o    // last_of_frame
);
  import pdmem_pkg::*;

  mode_e             mode_q;
  stage_t            stage;
  logic              take;
  logic [LevelW-1:0] level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENERGY;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  pdmem_popcnt u_popcnt (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .take_i          (take),
    .stage_o         (stage)
  );

  pdmem_accum u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (mode_q),
    .stage_i         (stage),
    .take_o          (take),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .level_o         (level),
    .last_o          (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {(OutDataW - LevelW)'(0), level};

  // input stalls only behind a staged beat blocked by a waiting result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (stage.vld && m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without a blocked result");

  // a new result always comes from a staged beat
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(stage.vld && take))
    else $error("result appeared without a staged beat");

  // the accumulator takes a beat only when the stage holds one
  a_take_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> stage.vld)
    else $error("accumulator took an empty stage");

endmodule

`default_nettype wire

/* hw/rtl/pdmem_popcnt.sv */
// ----------------------------------------------------------------------------
// pdmem_popcnt
// Input register: counts the ones of each accepted PDM word and holds the
// count until the accumulator takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pdmem_popcnt (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  wire [pdmem_pkg::WordW-1:0]   s_axis_tdata_i,
  input  wire                          take_i,
  output pdmem_pkg::stage_t            stage_o
);
  import pdmem_pkg::*;

  logic            vld_q;
  logic [CntW-1:0] ones_q;
  logic            load;

  assign load            = !vld_q || take_i;
  assign s_axis_tready_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && s_axis_tvalid_i) begin
      ones_q <= popcount(s_axis_tdata_i);
    end
  end

  assign stage_o.vld  = vld_q;
  assign stage_o.ones = ones_q;

endmodule

`default_nettype wire

/* hw/rtl/pdmem_accum.sv */
// ----------------------------------------------------------------------------
// pdmem_accum
// Frame accumulator: tracks the word position, the open group count and the
// frame energy, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdmem_accum (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire pdmem_pkg::mode_e         mode_i,
  input  wire pdmem_pkg::stage_t        stage_i,
  output logic                          take_o,
  output logic                          m_axis_tvalid_o,
  input  wire                           m_axis_tready_i,
  output logic [pdmem_pkg::LevelW-1:0]  level_o,
  output logic                          last_o
);
  import pdmem_pkg::*;

  logic [PosW-1:0]   pos_q, pos_d;
  logic [OnesW-1:0]  group_q, group_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic              out_vld_q;
  logic [LevelW-1:0] level_q, level_d;
  logic              last_q;

  logic              frame_end, group_end, pair_end, emits, out_free;
  logic [OnesW-1:0]  ones;
  logic [DevW-1:0]   dev;
  logic [SqW-1:0]    sq;
  logic [SumW:0]     sum_wide;
  logic [SumW-1:0]   sum_sat;

  assign frame_end = (pos_q == LastPos);
  assign group_end = (pos_q[1:0] == 2'b11) || frame_end;
  assign pair_end  = pos_q[0] || frame_end;
  assign ones      = group_q + OnesW'(stage_i.ones);

  // absolute deviation from the group center, then its square
  always_comb begin
    if (ones > GroupCenter) begin
      dev = DevW'(ones - GroupCenter);
    end else begin
      dev = DevW'(GroupCenter - ones);
    end
  end
  assign sq       = dev * dev;
  assign sum_wide = {1'b0, sum_q} + (SumW+1)'(sq);
  assign sum_sat  = sum_wide[SumW] ? EnergyMax : sum_wide[SumW-1:0];

  assign emits    = (mode_i == MODE_DENSITY) ? pair_end : frame_end;
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign take_o   = stage_i.vld && (!emits || out_free);

  always_comb begin
    pos_d   = pos_q;
    group_d = group_q;
    sum_d   = sum_q;
    level_d = LevelW'(ones);
    if (mode_i == MODE_ENERGY) begin
      if (group_end) begin
        group_d = '0;
        sum_d   = sum_sat;
      end else begin
        group_d = ones;
      end
      level_d = LevelW'(sum_sat >> EnergyShift);
    end else begin
      group_d = pair_end ? '0 : ones;
    end
    if (frame_end) begin
      pos_d = '0;
      sum_d = '0;
    end else begin
      pos_d = pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      group_q   <= '0;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (take_o) begin
        pos_q   <= pos_d;
        group_q <= group_d;
        sum_q   <= sum_d;
      end
      if (out_free) begin
        out_vld_q <= take_o && emits;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emits) begin
      level_q <= level_d;
      last_q  <= frame_end;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign level_o         = level_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire

/* tb/pdm_density_energy_meter_test.sv */
// ----------------------------------------------------------------------------
// pdm_density_energy_meter_test
// Streams PDM words through the meter in energy and density mode, with mode
// switches inside frames and groups, random sender bursts and receiver stalls.
// Every result beat is checked against a cycle-free model of the frame energy
// and pair ones count kept in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pdm_density_energy_meter_test;
  import pdmem_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MinWords   = 600;
  localparam int unsigned MinLevels  = 48;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              last;
  } level_beat_t;

  typedef enum int {WORD_RANDOM, WORD_DENSE, WORD_SPARSE, WORD_RAIL, WORD_MIXED} word_style_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_GATED} rx_style_e;

  class level_scoreboard;
    mode_e             mode;
    logic [PosW-1:0]   pos;
    logic [OnesW-1:0]  run_ones;
    logic [SumW-1:0]   energy;
    level_beat_t       pending[$];
    int unsigned       errors;
    int unsigned       predicted;

    function new();
      mode = MODE_ENERGY;
      pos = '0;
      run_ones = '0;
      energy = '0;
      errors = 0;
      predicted = 0;
    endfunction

    function void push_level(logic [LevelW-1:0] level, logic last);
      level_beat_t b;
      b.level = level;
      b.last = last;
      pending.push_back(b);
      predicted++;
    endfunction

    // one accepted pdm word
    function void note_word(logic [WordW-1:0] w);
      logic [OnesW-1:0] ones;
      logic             frame_end;
      int unsigned      dev;
      int unsigned      sum;
      ones = run_ones + OnesW'($countones(w));
      frame_end = (pos == LastPos);
      if (mode == MODE_ENERGY) begin
        if (pos[1:0] == 2'b11 || frame_end) begin
          dev = (ones > GroupCenter) ? ones - GroupCenter : GroupCenter - ones;
          sum = energy + dev * dev;
          energy = (sum > EnergyMax) ? EnergyMax : SumW'(sum);
          run_ones = '0;
        end else begin
          run_ones = ones;
        end
        if (frame_end) push_level(LevelW'(energy >> EnergyShift), 1'b1);
      end else begin
        if (pos[0] || frame_end) begin
          push_level(LevelW'(ones), frame_end);
          run_ones = '0;
        end else begin
          run_ones = ones;
        end
      end
      if (frame_end) begin
        energy = '0;
        pos = '0;
      end else begin
        pos = pos + 1'b1;
      end
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("%0t mismatch: %s", $realtime, what);
    endfunction

    function void check_beat(logic [OutDataW-1:0] data, logic last);
      level_beat_t exp_beat;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected beat data=%0d last=%0b", data, last));
        return;
      end
      exp_beat = pending.pop_front();
      if (data !== OutDataW'(exp_beat.level))
        flag($sformatf("level expected %0d got %0d", exp_beat.level, data));
      if (last !== exp_beat.last)
        flag($sformatf("last expected %0b got %0b", exp_beat.last, last));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [WordW-1:0]    s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;

  level_scoreboard sb = new();
  int unsigned     cycles = 0;
  int unsigned     words_sent = 0;
  int unsigned     burst_left = 0;
  rx_style_e       rx_style = RX_OPEN;
  int unsigned     rx_left = 0;

  pdm_density_energy_meter dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check accepted beats and stall on a pattern that changes now and then
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
    if (rx_left == 0) begin
      rx_style <= rx_style_e'($urandom_range(RX_OPEN, RX_GATED));
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      RX_OPEN: m_tready <= 1'b1;
      RX_COIN: m_tready <= 1'($urandom_range(0, 1));
      RX_SLOW: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (cycles % 16) < 4;
    endcase
  end

  function automatic logic [WordW-1:0] make_word(word_style_e style);
    word_style_e s;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    s = style;
    if (s == WORD_MIXED) s = word_style_e'($urandom_range(WORD_RANDOM, WORD_RAIL));
    a = WordW'($urandom);
    b = WordW'($urandom);
    c = WordW'($urandom);
    case (s)
      WORD_DENSE:  return a | b | c;
      WORD_SPARSE: return a & b & c;
      WORD_RAIL:   return $urandom_range(0, 1) ? {WordW{1'b1}} : '0;
      default:     return a;
    endcase
  endfunction

  // one word; the sender pauses between bursts of random length
  task automatic send_word(logic [WordW-1:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    do @(posedge clk); while (!s_tready);
    sb.note_word(w);
    words_sent++;
    burst_left--;
  endtask

  // wait for all results plus the pipeline depth so no word is still in flight
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(mode_e m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.mode = m;
  endtask

  initial begin
    mode_e       m;
    word_style_e style;
    int unsigned n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // energy words leave an open group behind
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h0001);
    send_word(16'h8000);
    send_word(16'hAAAA);
    // density in mid group: the carried count lands in the first pair
    set_mode(MODE_DENSITY);
    send_word(16'h5555);
    send_word(16'hFFFF);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'h0000);
    send_word(16'h8001);
    send_word(16'h7FFE);
    send_word(16'h0F0F);
    send_word(16'hF0F0);
    send_word(16'hFFFF);
    // back to energy with half a pair open
    set_mode(MODE_ENERGY);
    send_word(16'hFFFF);

    while (words_sent < MinWords || sb.predicted < MinLevels) begin
      m = mode_e'($urandom_range(0, 1));
      set_mode(m);
      n = (m == MODE_ENERGY) ? $urandom_range(40, 200) : $urandom_range(5, 80);
      style = word_style_e'($urandom_range(WORD_RANDOM, WORD_MIXED));
      repeat (n) send_word(make_word(style));
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
